// ----- hdl/ulcc_pkg.sv -----
// Shared types, codes and letter tables for the Cyrillic last-letter classifier.
`default_nettype none

package ulcc_pkg;

	localparam int unsigned ACCUM_W   = 21;
	localparam int unsigned PEND_W    = 2;
	localparam int unsigned LETTER_W  = 11;
	localparam int unsigned ERR_W     = 2;
	localparam int unsigned VERDICT_W = 3;

	localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
	localparam logic [ERR_W-1:0] ERR_CHAR = 2'd1;
	localparam logic [ERR_W-1:0] ERR_UTF8 = 2'd2;

	localparam logic [VERDICT_W-1:0] VERDICT_VOWEL     = 3'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_CONSONANT = 3'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_NO_LETTER = 3'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_BAD_CHAR  = 3'd3;
	localparam logic [VERDICT_W-1:0] VERDICT_BAD_UTF8  = 3'd4;

	localparam logic [ACCUM_W-1:0] CP_CR = 21'h0000D;
	localparam logic [ACCUM_W-1:0] CP_LF = 21'h0000A;

	localparam logic [ACCUM_W-1:0] CP_BIG_A  = 21'd1040;
	localparam logic [ACCUM_W-1:0] CP_SMALL_YA = 21'd1103;
	localparam logic [ACCUM_W-1:0] CP_BIG_YO = 21'd1025;
	localparam logic [ACCUM_W-1:0] CP_SMALL_YO = 21'd1105;

	typedef struct packed {
		logic [ACCUM_W-1:0]  code_accum;
		logic [PEND_W-1:0]   bytes_pending;
		logic [LETTER_W-1:0] last_letter;
		logic [ERR_W-1:0]    error_kind;
	} word_state_t;

	localparam word_state_t WORD_STATE_CLEAR = '0;

	// Russian letter: A..ya block, plus YO in both cases.
	function automatic logic is_letter(input logic [ACCUM_W-1:0] cp);
		is_letter = (cp >= CP_BIG_A && cp <= CP_SMALL_YA) || cp == CP_BIG_YO ||
			cp == CP_SMALL_YO;
	endfunction

	function automatic logic is_vowel(input logic [LETTER_W-1:0] cp);
		logic hit;
		hit = 1'b0;
		unique case (cp)
			11'd1025, 11'd1040, 11'd1045, 11'd1048, 11'd1054,
			11'd1059, 11'd1067, 11'd1069, 11'd1070, 11'd1071,
			11'd1072, 11'd1077, 11'd1080, 11'd1086, 11'd1091,
			11'd1099, 11'd1101, 11'd1102, 11'd1103, 11'd1105: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		is_vowel = hit;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/utf8_cyrillic_last_letter_classifier_top.sv -----
// Top level of the UTF-8 Cyrillic last-letter classifier.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------
//  in      | into      | in_valid/in_stall  | byte_valid, data_byte, end_of_word
//  out     | out of    | out_valid/out_stall| verdict, letter_code
//
// One byte per cycle while in_stall is low. A request is held in the input register,
// is decoded there against the word state, and a word's verdict is then registered
// into the result register.
// Reset clears the word state and both valid flags; no clearing pass.
// in_stall rises only when an end-of-word request waits in the input register while
// the result register still holds an untaken verdict.
`default_nettype none

module utf8_cyrillic_last_letter_classifier_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                byte_valid,
	input  wire logic [7:0]                          data_byte,
	input  wire logic                                end_of_word,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [ulcc_pkg::VERDICT_W-1:0]           verdict,
	output logic [ulcc_pkg::LETTER_W-1:0]            letter_code
);

	logic        valid_s1;
	logic        byte_valid_s1;
	logic [7:0]  data_byte_s1;
	logic        eow_s1;

	ulcc_pkg::word_state_t                state_q;
	ulcc_pkg::word_state_t                state_nxt;
	logic [ulcc_pkg::VERDICT_W-1:0]       verdict_nxt;
	logic [ulcc_pkg::LETTER_W-1:0]        letter_nxt;

	logic                                 out_valid_q;
	logic [ulcc_pkg::VERDICT_W-1:0]       verdict_q;
	logic [ulcc_pkg::LETTER_W-1:0]        letter_q;

	logic out_free;
	logic s1_done;
	logic take_in;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_done  = valid_s1 && (!eow_s1 || out_free);
	assign in_stall = valid_s1 && eow_s1 && !out_free;
	assign take_in  = in_valid && !in_stall;

	ulcc_decode u_decode (
		.cur         (state_q),
		.byte_valid  (byte_valid_s1),
		.data_byte   (data_byte_s1),
		.end_of_word (eow_s1),
		.nxt         (state_nxt),
		.verdict     (verdict_nxt),
		.letter_code (letter_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_valid_s1 <= byte_valid;
			data_byte_s1  <= data_byte;
			eow_s1        <= end_of_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ulcc_pkg::WORD_STATE_CLEAR;
		end else if (s1_done) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_done && eow_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load a verdict only when the word closes; hold it while stalled.
	always_ff @(posedge clk) begin
		if (s1_done && eow_s1) begin
			verdict_q <= verdict_nxt;
			letter_q  <= letter_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign verdict     = verdict_q;
	assign letter_code = letter_q;

endmodule

`default_nettype wire

// ----- hdl/ulcc_decode.sv -----
// One decode step: folds a byte into the word state and forms the verdict.
`default_nettype none

module ulcc_decode (
	input  wire ulcc_pkg::word_state_t                 cur,
	input  wire logic                                  byte_valid,
	input  wire logic [7:0]                            data_byte,
	input  wire logic                                  end_of_word,
	output ulcc_pkg::word_state_t                      nxt,
	output logic [ulcc_pkg::VERDICT_W-1:0]             verdict,
	output logic [ulcc_pkg::LETTER_W-1:0]              letter_code
);

	ulcc_pkg::word_state_t upd;
	logic                             fin;
	logic [ulcc_pkg::ACCUM_W-1:0]     fin_cp;

	always_comb begin
		upd    = cur;
		fin    = 1'b0;
		fin_cp = '0;
		if (byte_valid && cur.error_kind == ulcc_pkg::ERR_NONE) begin
			if (cur.bytes_pending == '0) begin
				priority if (!data_byte[7]) begin
					fin    = 1'b1;
					fin_cp = {13'd0, data_byte};
				end else if (data_byte[7:5] == 3'b110) begin
					upd.code_accum    = {16'd0, data_byte[4:0]};
					upd.bytes_pending = 2'd1;
				end else if (data_byte[7:4] == 4'b1110) begin
					upd.code_accum    = {17'd0, data_byte[3:0]};
					upd.bytes_pending = 2'd2;
				end else if (data_byte[7:3] == 5'b11110) begin
					upd.code_accum    = {18'd0, data_byte[2:0]};
					upd.bytes_pending = 2'd3;
				end else begin
					// stray continuation or lead byte 0xF8 and up
					upd.error_kind = ulcc_pkg::ERR_UTF8;
				end
			end else if (data_byte[7:6] != 2'b10) begin
				upd.error_kind = ulcc_pkg::ERR_UTF8;
			end else begin
				upd.code_accum    = {cur.code_accum[14:0], data_byte[5:0]};
				upd.bytes_pending = cur.bytes_pending - 2'd1;
				if (cur.bytes_pending == 2'd1) begin
					fin    = 1'b1;
					fin_cp = {cur.code_accum[14:0], data_byte[5:0]};
				end
			end
		end
		// Skip CR and LF; keep letters; anything else is a bad character.
		if (fin && fin_cp != ulcc_pkg::CP_CR && fin_cp != ulcc_pkg::CP_LF) begin
			if (ulcc_pkg::is_letter(fin_cp)) begin
				upd.last_letter = fin_cp[ulcc_pkg::LETTER_W-1:0];
			end else begin
				upd.error_kind = ulcc_pkg::ERR_CHAR;
			end
		end
		if (end_of_word && upd.error_kind == ulcc_pkg::ERR_NONE &&
			upd.bytes_pending != '0) begin
			upd.error_kind = ulcc_pkg::ERR_UTF8;
		end
	end

	always_comb begin
		priority if (upd.error_kind == ulcc_pkg::ERR_CHAR) begin
			verdict = ulcc_pkg::VERDICT_BAD_CHAR;
		end else if (upd.error_kind != ulcc_pkg::ERR_NONE) begin
			verdict = ulcc_pkg::VERDICT_BAD_UTF8;
		end else if (upd.last_letter == '0) begin
			verdict = ulcc_pkg::VERDICT_NO_LETTER;
		end else if (ulcc_pkg::is_vowel(upd.last_letter)) begin
			verdict = ulcc_pkg::VERDICT_VOWEL;
		end else begin
			verdict = ulcc_pkg::VERDICT_CONSONANT;
		end
	end

	assign letter_code = upd.last_letter;
	// Clear the word state once the word is closed.
	assign nxt = end_of_word ? ulcc_pkg::WORD_STATE_CLEAR : upd;

endmodule

`default_nettype wire

// ----- hdl/ulcc_checker.sv -----
// Port-level checks on the classifier's result channel, bound to the top level.
`default_nettype none

module ulcc_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                out_valid,
	input wire logic                                out_stall,
	input wire logic [ulcc_pkg::VERDICT_W-1:0]      verdict,
	input wire logic [ulcc_pkg::LETTER_W-1:0]       letter_code
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(letter_code))
		else $error("result changed while stalled");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> verdict <= ulcc_pkg::VERDICT_BAD_UTF8)
		else $error("verdict code out of range");

	a_no_letter_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == ulcc_pkg::VERDICT_NO_LETTER |-> letter_code == '0)
		else $error("no-letter verdict with a letter code");

	a_letter_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (verdict == ulcc_pkg::VERDICT_VOWEL ||
		verdict == ulcc_pkg::VERDICT_CONSONANT) |->
		ulcc_pkg::is_letter({10'd0, letter_code}))
		else $error("letter verdict without a Russian letter");

endmodule

bind utf8_cyrillic_last_letter_classifier_top ulcc_checker u_ulcc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.verdict     (verdict),
	.letter_code (letter_code)
);

`default_nettype wire
